>>> src/path_callsign_validator_assert.svh
// Assertion macros shared by the checker of the path callsign validator.
`ifndef PATH_CALLSIGN_VALIDATOR_ASSERT_SVH
`define PATH_CALLSIGN_VALIDATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PCV_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PCV_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/pcv_pkg.sv
`timescale 1ns / 1ps

package pcv_pkg;

    localparam int CH_W    = 8;
    localparam int CFG_W   = 4;
    localparam int CNT_W   = 5;
    localparam int IDX_W   = 2;
    localparam int PROD_W  = 9;

    localparam logic [CNT_W-1:0] SAT_MAX    = 5'd31;
    localparam logic [CNT_W-1:0] FIELDS_SAT = 5'd16;

    localparam logic [CFG_W-1:0] MAX_FIELDS_RST    = 4'd8;
    localparam logic [CFG_W-1:0] MAX_FIELD_LEN_RST = 4'd9;
    localparam logic [CFG_W-1:0] MAX_CALL_LEN_RST  = 4'd6;
    localparam logic [CFG_W-1:0] MAX_SSID_RST      = 4'd15;

    localparam logic [CH_W-1:0] CHAR_COMMA = 8'h2C;
    localparam logic [CH_W-1:0] CHAR_DASH  = 8'h2D;
    localparam logic [CH_W-1:0] CHAR_0     = 8'h30;
    localparam logic [CH_W-1:0] CHAR_9     = 8'h39;
    localparam logic [CH_W-1:0] CHAR_UA    = 8'h41;
    localparam logic [CH_W-1:0] CHAR_UZ    = 8'h5A;
    localparam logic [CH_W-1:0] CHAR_LA    = 8'h61;
    localparam logic [CH_W-1:0] CHAR_LZ    = 8'h7A;

    typedef enum logic [IDX_W-1:0] {
        REG_MAX_FIELDS,
        REG_MAX_FIELD_LEN,
        REG_MAX_CALL_LEN,
        REG_MAX_SSID
    } cfg_reg_t;

    typedef struct packed {
        logic             in_ssid;
        logic [CNT_W-1:0] call_length;
        logic [CNT_W-1:0] field_length;
        logic [CNT_W-1:0] ssid_value;
        logic             field_good;
    } field_state_t;

    localparam field_state_t FIELD_CLEAR = '{
        in_ssid:      1'b0,
        call_length:  '0,
        field_length: '0,
        ssid_value:   '0,
        field_good:   1'b1
    };

endpackage

>>> src/pcv_char_if.sv
`timescale 1ns / 1ps

interface pcv_char_if;
    logic                      valid;
    logic                      ready;
    logic [pcv_pkg::CH_W-1:0]  ch;
    logic                      last;

    modport source (output valid, output ch, output last, input ready);
    modport sink (input valid, input ch, input last, output ready);
endinterface

>>> src/pcv_verdict_if.sv
`timescale 1ns / 1ps

interface pcv_verdict_if;
    logic                       valid;
    logic                       ready;
    logic                       path_valid;
    logic [pcv_pkg::CNT_W-1:0]  field_count;

    modport source (output valid, output path_valid, output field_count, input ready);
    modport sink (input valid, input path_valid, input field_count, output ready);
endinterface

>>> src/path_callsign_validator.sv
`timescale 1ns / 1ps

// Checks a comma-separated path of callsigns arriving one character per transfer on chr and
// returns one verdict transfer on verdict for each character marked last, carrying whether
// the whole path was valid and how many fields it held. The block takes one character every
// cycle while no last character is held back; a character is registered in ch_reg, then the
// field and path counters are updated from it and, for a last character, the verdict is
// registered for output. A non-last character keeps flowing while a verdict waits; a last
// character waits in the character register until the previous verdict has been taken.
// The limit registers are written through cfg_wr_en, cfg_index and cfg_wdata and should only
// be changed between paths.
module path_callsign_validator (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [pcv_pkg::IDX_W-1:0]     cfg_index,
    input  logic [pcv_pkg::CFG_W-1:0]     cfg_wdata,
    pcv_char_if.sink                      chr,
    pcv_verdict_if.source                 verdict
);

    logic [pcv_pkg::CFG_W-1:0] max_fields_reg;
    logic [pcv_pkg::CFG_W-1:0] max_field_len_reg;
    logic [pcv_pkg::CFG_W-1:0] max_call_len_reg;
    logic [pcv_pkg::CFG_W-1:0] max_ssid_reg;

    logic                      s1_valid_reg;
    logic                      s1_valid_next;
    logic [pcv_pkg::CH_W-1:0]  ch_reg;
    logic                      last_reg;

    pcv_pkg::field_state_t     field_reg;
    pcv_pkg::field_state_t     field_next;
    logic [pcv_pkg::CNT_W-1:0] fields_seen_reg;
    logic [pcv_pkg::CNT_W-1:0] fields_seen_next;
    logic                      all_good_reg;
    logic                      all_good_next;

    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic                      path_valid_reg;
    logic                      path_valid_next;
    logic [pcv_pkg::CNT_W-1:0] field_count_reg;

    logic                      take;
    logic                      step;
    logic                      out_free;

    logic                      is_comma;
    logic                      is_dash;
    logic                      is_digit;
    logic                      is_letter;
    logic                      close;
    logic [pcv_pkg::CNT_W-1:0] digit_val;
    logic [pcv_pkg::PROD_W-1:0] ssid_acc;
    pcv_pkg::field_state_t     taken;
    pcv_pkg::field_state_t     closing;
    logic                      field_ok;

    assign out_free  = !out_valid_reg || verdict.ready;
    assign step      = s1_valid_reg && (!last_reg || out_free);
    assign chr.ready = !s1_valid_reg || step;
    assign take      = chr.valid && chr.ready;

    assign verdict.valid       = out_valid_reg;
    assign verdict.path_valid  = path_valid_reg;
    assign verdict.field_count = field_count_reg;

    always_comb
    begin
        is_comma  = (ch_reg == pcv_pkg::CHAR_COMMA);
        is_dash   = (ch_reg == pcv_pkg::CHAR_DASH);
        is_digit  = (ch_reg >= pcv_pkg::CHAR_0) && (ch_reg <= pcv_pkg::CHAR_9);
        is_letter = ((ch_reg >= pcv_pkg::CHAR_UA) && (ch_reg <= pcv_pkg::CHAR_UZ))
                 || ((ch_reg >= pcv_pkg::CHAR_LA) && (ch_reg <= pcv_pkg::CHAR_LZ));
        close     = is_comma || last_reg;
        digit_val = pcv_pkg::CNT_W'(ch_reg - pcv_pkg::CHAR_0);

        ssid_acc = {1'b0, field_reg.ssid_value, 3'b000}
                 + {3'b000, field_reg.ssid_value, 1'b0}
                 + {4'b0000, digit_val};

        taken = field_reg;
        if (field_reg.field_length != pcv_pkg::SAT_MAX)
        begin
            taken.field_length = field_reg.field_length + 1'b1;
        end
        if (field_reg.in_ssid)
        begin
            if (is_digit)
            begin
                if (ssid_acc > {4'b0000, pcv_pkg::SAT_MAX})
                begin
                    taken.ssid_value = pcv_pkg::SAT_MAX;
                end
                else
                begin
                    taken.ssid_value = ssid_acc[pcv_pkg::CNT_W-1:0];
                end
            end
            else
            begin
                taken.field_good = 1'b0;
            end
        end
        else if (is_dash)
        begin
            taken.in_ssid = 1'b1;
        end
        else if (is_letter || is_digit)
        begin
            if (field_reg.call_length != pcv_pkg::SAT_MAX)
            begin
                taken.call_length = field_reg.call_length + 1'b1;
            end
        end
        else
        begin
            taken.field_good = 1'b0;
        end

        // A comma closes the field as it stands; any other last character joins it first.
        closing  = is_comma ? field_reg : taken;
        field_ok = closing.field_good
                && (closing.field_length != '0)
                && (closing.field_length <= {1'b0, max_field_len_reg})
                && (closing.call_length != '0)
                && (closing.call_length <= {1'b0, max_call_len_reg})
                && (closing.ssid_value <= {1'b0, max_ssid_reg});

        all_good_next    = all_good_reg && (field_ok || !close);
        fields_seen_next = fields_seen_reg;
        if (close && (fields_seen_reg != pcv_pkg::FIELDS_SAT))
        begin
            fields_seen_next = fields_seen_reg + 1'b1;
        end
        path_valid_next = all_good_next && (fields_seen_next <= {1'b0, max_fields_reg});

        field_next = close ? pcv_pkg::FIELD_CLEAR : taken;

        s1_valid_next = take ? 1'b1 : (step ? 1'b0 : s1_valid_reg);
        out_valid_next = (step && last_reg) ? 1'b1 : (verdict.ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_fields_reg    <= pcv_pkg::MAX_FIELDS_RST;
            max_field_len_reg <= pcv_pkg::MAX_FIELD_LEN_RST;
            max_call_len_reg  <= pcv_pkg::MAX_CALL_LEN_RST;
            max_ssid_reg      <= pcv_pkg::MAX_SSID_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (pcv_pkg::cfg_reg_t'(cfg_index))
                pcv_pkg::REG_MAX_FIELDS:    max_fields_reg    <= cfg_wdata;
                pcv_pkg::REG_MAX_FIELD_LEN: max_field_len_reg <= cfg_wdata;
                pcv_pkg::REG_MAX_CALL_LEN:  max_call_len_reg  <= cfg_wdata;
                pcv_pkg::REG_MAX_SSID:      max_ssid_reg      <= cfg_wdata;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            field_reg       <= pcv_pkg::FIELD_CLEAR;
            fields_seen_reg <= '0;
            all_good_reg    <= 1'b1;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (step)
            begin
                field_reg <= field_next;
                if (last_reg)
                begin
                    fields_seen_reg <= '0;
                    all_good_reg    <= 1'b1;
                end
                else
                begin
                    fields_seen_reg <= fields_seen_next;
                    all_good_reg    <= all_good_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            ch_reg   <= chr.ch;
            last_reg <= chr.last;
        end
        if (step && last_reg)
        begin
            path_valid_reg  <= path_valid_next;
            field_count_reg <= fields_seen_next;
        end
    end

endmodule

>>> src/pcv_checker.sv
`timescale 1ns / 1ps

`include "path_callsign_validator_assert.svh"

module pcv_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      chr_ready,
    input logic                      out_valid,
    input logic                      out_ready,
    input logic                      out_path_valid,
    input logic [pcv_pkg::CNT_W-1:0] out_field_count
);

    logic                        count_ok;
    logic                        valid_path;
    logic                        fits_limit;
    logic                        out_stalled;
    logic [pcv_pkg::CNT_W+1:0]   out_word;

    assign count_ok    = (out_field_count != '0) && (out_field_count <= pcv_pkg::FIELDS_SAT);
    assign valid_path  = out_valid && out_path_valid;
    assign fits_limit  = (out_field_count <= 5'd15);
    assign out_stalled = out_valid && !out_ready;
    assign out_word    = {out_valid, out_path_valid, out_field_count};

    // Every path closes at least one field, and the count saturates at sixteen.
    `PCV_ASSERT_NOW(a_count_range, out_valid, count_ok, "field count out of range")

    // A valid path never holds more fields than the largest possible limit.
    `PCV_ASSERT_NOW(a_valid_count, valid_path, fits_limit, "valid path with too many fields")

    // With no verdict pending the character side can always take a transfer.
    `PCV_ASSERT_NOW(a_ready_when_empty, !out_valid, chr_ready, "input stalled with empty output")

    `PCV_ASSERT_NEXT(a_out_hold, out_stalled, $stable(out_word), "stalled verdict changed")

endmodule

bind path_callsign_validator pcv_checker u_pcv_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .chr_ready       (chr.ready),
    .out_valid       (verdict.valid),
    .out_ready       (verdict.ready),
    .out_path_valid  (verdict.path_valid),
    .out_field_count (verdict.field_count)
);

>>> bench/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int STALL_LIMIT   = 2000;
    localparam int PHASE_CHARS   = 240;
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASES        = 8;

    typedef logic [pcv_pkg::CH_W-1:0] char_q_t[$];

    typedef struct packed {
        logic                      path_valid;
        logic [pcv_pkg::CNT_W-1:0] field_count;
    } verdict_t;

    class path_verdict_book;
        logic [pcv_pkg::CFG_W-1:0] lim_fields;
        logic [pcv_pkg::CFG_W-1:0] lim_field_len;
        logic [pcv_pkg::CFG_W-1:0] lim_call_len;
        logic [pcv_pkg::CFG_W-1:0] lim_ssid;
        logic                      in_ssid;
        logic                      all_good;
        logic                      field_good;
        logic [pcv_pkg::CNT_W-1:0] call_len;
        logic [pcv_pkg::CNT_W-1:0] field_len;
        logic [pcv_pkg::CNT_W-1:0] ssid_val;
        logic [pcv_pkg::CNT_W-1:0] fields_seen;
        verdict_t                  pending[$];
        int                        errors;

        function new();
            lim_fields    = pcv_pkg::MAX_FIELDS_RST;
            lim_field_len = pcv_pkg::MAX_FIELD_LEN_RST;
            lim_call_len  = pcv_pkg::MAX_CALL_LEN_RST;
            lim_ssid      = pcv_pkg::MAX_SSID_RST;
            errors        = 0;
            clear_path();
        endfunction

        function void set_limit(pcv_pkg::cfg_reg_t idx, logic [pcv_pkg::CFG_W-1:0] v);
            case (idx)
                pcv_pkg::REG_MAX_FIELDS:    lim_fields    = v;
                pcv_pkg::REG_MAX_FIELD_LEN: lim_field_len = v;
                pcv_pkg::REG_MAX_CALL_LEN:  lim_call_len  = v;
                pcv_pkg::REG_MAX_SSID:      lim_ssid      = v;
                default: ;
            endcase
        endfunction

        function logic [pcv_pkg::CNT_W-1:0] bump(logic [pcv_pkg::CNT_W-1:0] v,
                                                 logic [pcv_pkg::CNT_W-1:0] top);
            return (v >= top) ? top : v + 1'b1;
        endfunction

        function void clear_field();
            in_ssid    = 1'b0;
            call_len   = '0;
            field_len  = '0;
            ssid_val   = '0;
            field_good = 1'b1;
        endfunction

        function void clear_path();
            clear_field();
            fields_seen = '0;
            all_good    = 1'b1;
        endfunction

        function void close_field();
            if (!(field_good && field_len >= 1 && field_len <= lim_field_len
                  && call_len >= 1 && call_len <= lim_call_len && ssid_val <= lim_ssid))
                all_good = 1'b0;
            fields_seen = bump(fields_seen, pcv_pkg::FIELDS_SAT);
            clear_field();
        endfunction

        function void note_char(logic [pcv_pkg::CH_W-1:0] c, logic last);
            int       v;
            logic     is_digit;
            logic     is_letter;
            verdict_t exp;
            is_digit  = (c >= pcv_pkg::CHAR_0 && c <= pcv_pkg::CHAR_9);
            is_letter = (c >= pcv_pkg::CHAR_UA && c <= pcv_pkg::CHAR_UZ)
                     || (c >= pcv_pkg::CHAR_LA && c <= pcv_pkg::CHAR_LZ);
            if (c == pcv_pkg::CHAR_COMMA)
            begin
                close_field();
            end
            else
            begin
                field_len = bump(field_len, pcv_pkg::SAT_MAX);
                if (in_ssid)
                begin
                    if (is_digit)
                    begin
                        v = int'(ssid_val) * 10 + int'(c) - int'(pcv_pkg::CHAR_0);
                        ssid_val = (v > int'(pcv_pkg::SAT_MAX)) ?
                                   pcv_pkg::SAT_MAX : v[pcv_pkg::CNT_W-1:0];
                    end
                    else
                    begin
                        field_good = 1'b0;
                    end
                end
                else if (c == pcv_pkg::CHAR_DASH)
                begin
                    in_ssid = 1'b1;
                end
                else if (is_letter || is_digit)
                begin
                    call_len = bump(call_len, pcv_pkg::SAT_MAX);
                end
                else
                begin
                    field_good = 1'b0;
                end
                if (last)
                    close_field();
            end
            if (last)
            begin
                exp.path_valid  = all_good && (fields_seen <= lim_fields);
                exp.field_count = fields_seen;
                pending.push_back(exp);
                clear_path();
            end
        endfunction

        function void check_verdict(logic pv, logic [pcv_pkg::CNT_W-1:0] fc);
            verdict_t exp;
            if (pending.size() == 0)
            begin
                $display("%0t: verdict with none expected: path_valid=%0b field_count=%0d",
                         $time, pv, fc);
                errors++;
            end
            else
            begin
                exp = pending.pop_front();
                if (pv !== exp.path_valid)
                begin
                    $display("%0t: path_valid expected %0b actual %0b",
                             $time, exp.path_valid, pv);
                    errors++;
                end
                if (fc !== exp.field_count)
                begin
                    $display("%0t: field_count expected %0d actual %0d",
                             $time, exp.field_count, fc);
                    errors++;
                end
            end
        endfunction
    endclass

    logic                        clk;
    logic                        rst_n;
    logic                        cfg_wr_en;
    logic [pcv_pkg::IDX_W-1:0]   cfg_index;
    logic [pcv_pkg::CFG_W-1:0]   cfg_wdata;
    int                          send_idle_pct = 0;
    int                          recv_stall_pct = 0;
    int                          chars_sent = 0;
    int                          quiet_cycles = 0;
    path_verdict_book            book = new();

    pcv_char_if    chr_bus();
    pcv_verdict_if verdict_bus();

    path_callsign_validator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .chr       (chr_bus),
        .verdict   (verdict_bus)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic logic [pcv_pkg::CH_W-1:0] call_char();
        int r;
        r = $urandom_range(61);
        if (r < 10)
            return pcv_pkg::CHAR_0 + pcv_pkg::CH_W'(r);
        else if (r < 36)
            return pcv_pkg::CHAR_UA + pcv_pkg::CH_W'(r - 10);
        else
            return pcv_pkg::CHAR_LA + pcv_pkg::CH_W'(r - 36);
    endfunction

    function automatic char_q_t text_path(string s);
        char_q_t p;
        for (int i = 0; i < s.len(); i++)
            p.push_back(s[i]);
        return p;
    endfunction

    task automatic build_random_path(output char_q_t p);
        int kind;
        int nf;
        int clen;
        int dlen;
        int cap_calls;
        int cap_fields;
        int r;
        kind = $urandom_range(99);
        p = {};
        cap_calls  = (book.lim_call_len == 0) ? 1 : int'(book.lim_call_len);
        cap_fields = (book.lim_fields == 0) ? 1 : int'(book.lim_fields);
        if (kind < 85)
        begin
            nf = ($urandom_range(9) == 0) ? cap_fields + 1 : $urandom_range(cap_fields, 1);
            for (int f = 0; f < nf; f++)
            begin
                if (f != 0)
                    p.push_back(pcv_pkg::CHAR_COMMA);
                clen = ($urandom_range(9) == 0) ? cap_calls + 1 : $urandom_range(cap_calls, 1);
                repeat (clen)
                    p.push_back(call_char());
                if ($urandom_range(1) == 1)
                begin
                    p.push_back(pcv_pkg::CHAR_DASH);
                    dlen = ($urandom_range(9) == 0) ? 0 : (($urandom_range(2) == 0) ? 2 : 1);
                    if (dlen == 2)
                        p.push_back(($urandom_range(3) == 0) ?
                                    pcv_pkg::CHAR_0 + pcv_pkg::CH_W'($urandom_range(9)) :
                                    pcv_pkg::CHAR_0 + 8'd1);
                    if (dlen != 0)
                        p.push_back(pcv_pkg::CHAR_0 + pcv_pkg::CH_W'($urandom_range(9)));
                end
            end
            if ($urandom_range(9) == 0)
                p.push_back(pcv_pkg::CHAR_COMMA);
            if (kind >= 70)
            begin
                repeat ($urandom_range(2, 1))
                begin
                    r = $urandom_range(3);
                    p[$urandom_range(p.size() - 1)] =
                        (r == 0) ? pcv_pkg::CHAR_COMMA :
                        (r == 1) ? pcv_pkg::CHAR_DASH : pcv_pkg::CH_W'($urandom_range(255));
                end
            end
        end
        else if (kind < 95)
        begin
            repeat ($urandom_range(12, 1))
            begin
                r = $urandom_range(3);
                case (r)
                    0: p.push_back(pcv_pkg::CH_W'($urandom_range(255)));
                    1: p.push_back(pcv_pkg::CHAR_COMMA);
                    2: p.push_back(pcv_pkg::CHAR_DASH);
                    default: p.push_back(call_char());
                endcase
            end
        end
        else
        begin
            r = $urandom_range(2);
            if (r == 0)
            begin
                repeat ($urandom_range(36, 30))
                    p.push_back(call_char());
            end
            else if (r == 1)
            begin
                p.push_back(call_char());
                p.push_back(pcv_pkg::CHAR_DASH);
                repeat ($urandom_range(4, 3))
                    p.push_back(pcv_pkg::CHAR_0 + pcv_pkg::CH_W'($urandom_range(9)));
            end
            else
            begin
                repeat ($urandom_range(20, 15))
                begin
                    p.push_back(call_char());
                    p.push_back(pcv_pkg::CHAR_COMMA);
                end
                p.push_back(call_char());
            end
        end
    endtask

    task automatic send_path(input char_q_t p);
        for (int i = 0; i < p.size(); i++)
        begin
            @(negedge clk);
            while ($urandom_range(99) < send_idle_pct)
            begin
                chr_bus.valid = 1'b0;
                @(negedge clk);
            end
            chr_bus.valid = 1'b1;
            chr_bus.ch    = p[i];
            chr_bus.last  = (i == p.size() - 1);
            do @(posedge clk); while (!chr_bus.ready);
            book.note_char(p[i], chr_bus.last);
            chars_sent++;
        end
    endtask

    task automatic write_limit(pcv_pkg::cfg_reg_t idx, logic [pcv_pkg::CFG_W-1:0] v);
        @(negedge clk);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_wdata = v;
        book.set_limit(idx, v);
    endtask

    task automatic write_limits(logic [pcv_pkg::CFG_W-1:0] f, logic [pcv_pkg::CFG_W-1:0] fl,
                                logic [pcv_pkg::CFG_W-1:0] cl, logic [pcv_pkg::CFG_W-1:0] s);
        write_limit(pcv_pkg::REG_MAX_FIELDS, f);
        write_limit(pcv_pkg::REG_MAX_FIELD_LEN, fl);
        write_limit(pcv_pkg::REG_MAX_CALL_LEN, cl);
        write_limit(pcv_pkg::REG_MAX_SSID, s);
        @(negedge clk);
        cfg_wr_en = 1'b0;
    endtask

    task automatic drain();
        @(negedge clk);
        chr_bus.valid = 1'b0;
        while (book.pending.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    initial
    begin
        verdict_bus.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            verdict_bus.ready = ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && verdict_bus.valid && verdict_bus.ready)
                book.check_verdict(verdict_bus.path_valid, verdict_bus.field_count);
        end
    end

    initial
    begin
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((chr_bus.valid && chr_bus.ready) || (verdict_bus.valid && verdict_bus.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        char_q_t path;
        int      start;
        rst_n         = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_index     = pcv_pkg::REG_MAX_FIELDS;
        cfg_wdata     = '0;
        chr_bus.valid = 1'b0;
        chr_bus.ch    = '0;
        chr_bus.last  = 1'b0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase % 4)
                0:
                begin
                    send_idle_pct = 0;  recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 73; recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;  recv_stall_pct = 73;
                end
                default:
                begin
                    send_idle_pct = 13; recv_stall_pct = 13;
                end
            endcase
            case (phase)
                1: write_limits(4'd15, 4'd15, 4'd15, 4'd15);
                2: write_limits(4'd0, 4'd0, 4'd0, 4'd0);
                3: write_limits(4'd1, 4'd1, 4'd1, 4'd0);
                5: write_limits(4'd3, 4'd6, 4'd2, 4'd9);
                7: write_limits(pcv_pkg::MAX_FIELDS_RST, pcv_pkg::MAX_FIELD_LEN_RST,
                                pcv_pkg::MAX_CALL_LEN_RST, pcv_pkg::MAX_SSID_RST);
                4, 6: write_limits(pcv_pkg::CFG_W'($urandom_range(15)),
                                   pcv_pkg::CFG_W'($urandom_range(15)),
                                   pcv_pkg::CFG_W'($urandom_range(15)),
                                   pcv_pkg::CFG_W'($urandom_range(15)));
                default: ;
            endcase
            if (phase == 0)
            begin
                path.delete();
                path.push_back(8'h00);
                send_path(path);
                path[0] = 8'hFF;
                send_path(path);
                send_path(text_path(","));
                send_path(text_path("z9-15,"));
                send_path(text_path("A,,B"));
                send_path(text_path("-5"));
                send_path(text_path("Q1--2"));
                send_path(text_path("a"));
            end
            start = chars_sent;
            while (chars_sent - start < PHASE_CHARS)
            begin
                build_random_path(path);
                send_path(path);
            end
            drain();
        end

        if (book.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
